// ===== hw/rtl/tass_pkg.sv =====
// Shared types, widths and helper functions for the two-axis stepper sequencer.
package tass_pkg;

  // Counter widths
  localparam int STEP_BITS   = 16;
  localparam int PERIOD_BITS = 8;

  // Fixed field and register widths
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  localparam logic [STEP_BITS-1:0]   STEP_MAX   = '1;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PERIOD = 2'd1;

  // Item kinds carried on tuser
  localparam logic ACT_MOVE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Axis codes
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Reset values
  localparam logic [1:0]       PHASE_RESET  = 2'd3;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd15;

  typedef struct packed {
    logic               action;
    logic               axis;
    logic               direction;
    logic [COUNT_W-1:0] step_count;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic       move_done;
    logic       busy_res;
    logic [3:0] y_coils;
    logic [3:0] x_coils;
  } result_t;

  // Two-coil-on drive pattern per phase: bit0 A, bit1 A-not, bit2 B, bit3 B-not
  function automatic logic [3:0] coil_of(input logic [1:0] phase);
    logic [3:0] c;
    case (phase)
      2'd0:    c = 4'h5;
      2'd1:    c = 4'h6;
      2'd2:    c = 4'hA;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  // Step period: zero means one tick, saturate to the wait counter range
  function automatic logic [PERIOD_BITS-1:0] period_sat(input logic [CFG_W-1:0] p);
    logic [PERIOD_BITS-1:0] r;
    if (p == '0) begin
      r = PERIOD_BITS'(1);
    end else if (32'(p) > 32'(PERIOD_MAX)) begin
      r = PERIOD_MAX;
    end else begin
      r = PERIOD_BITS'(p);
    end
    return r;
  endfunction

  // Step count saturated to the step counter range
  function automatic logic [STEP_BITS-1:0] count_sat(input logic [COUNT_W-1:0] c);
    logic [STEP_BITS-1:0] r;
    if (32'(c) > 32'(STEP_MAX)) begin
      r = STEP_MAX;
    end else begin
      r = STEP_BITS'(c);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tass_core.sv =====
// Motion state, period registers and per-item result logic.
module tass_core import tass_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 proc,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output result_t              res
);

  logic [CFG_W-1:0]       x_period;
  logic [CFG_W-1:0]       y_period;
  logic [1:0]             x_phase, x_phase_next;
  logic [1:0]             y_phase, y_phase_next;
  logic                   moving, moving_next;
  logic                   moving_axis, moving_axis_next;
  logic                   moving_backward, moving_backward_next;
  logic [STEP_BITS-1:0]   steps_left, steps_left_next;
  logic [PERIOD_BITS-1:0] wait_left, wait_left_next;

  logic                   take_step;
  logic                   step_axis;
  logic                   step_back;
  logic [STEP_BITS-1:0]   cnt;
  logic [PERIOD_BITS-1:0] wait_dec;
  logic                   done;
  logic                   rej;

  // Period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_period <= PERIOD_RESET;
      y_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_X_PERIOD) x_period <= cfg_data;
      if (cfg_index == REG_Y_PERIOD) y_period <= cfg_data;
    end
  end

  // Command and tick handling
  always_comb begin
    moving_next          = moving;
    moving_axis_next     = moving_axis;
    moving_backward_next = moving_backward;
    steps_left_next      = steps_left;
    wait_left_next       = wait_left;
    take_step            = 1'b0;
    done                 = 1'b0;
    rej                  = 1'b0;
    cnt                  = count_sat(item.step_count);
    wait_dec             = (wait_left != '0) ? wait_left - 1'b1 : '0;
    if (item.action == ACT_MOVE) begin
      if (moving) begin
        rej = 1'b1;
      end else if (cnt == '0) begin
        done = 1'b1;
      end else begin
        moving_next          = 1'b1;
        moving_axis_next     = item.axis;
        moving_backward_next = item.direction;
        steps_left_next      = cnt - 1'b1;
        take_step            = 1'b1;
      end
    end else if (moving) begin
      wait_left_next = wait_dec;
      if (wait_dec == '0) begin
        if (steps_left == '0) begin
          moving_next = 1'b0;
          done        = 1'b1;
        end else begin
          steps_left_next = steps_left - 1'b1;
          take_step       = 1'b1;
        end
      end
    end
    // A step reloads the wait with the moving axis's period
    if (take_step) begin
      wait_left_next = period_sat(moving_axis_next == AXIS_Y ? y_period : x_period);
    end
  end

  // Phase advance for a step
  always_comb begin
    step_axis    = moving_axis_next;
    step_back    = moving_backward_next;
    x_phase_next = x_phase;
    y_phase_next = y_phase;
    if (take_step) begin
      if (step_axis == AXIS_Y) begin
        y_phase_next = step_back ? y_phase - 2'd1 : y_phase + 2'd1;
      end else begin
        x_phase_next = step_back ? x_phase - 2'd1 : x_phase + 2'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_phase         <= PHASE_RESET;
      y_phase         <= PHASE_RESET;
      moving          <= 1'b0;
      moving_axis     <= AXIS_X;
      moving_backward <= 1'b0;
      steps_left      <= '0;
      wait_left       <= '0;
    end else if (proc) begin
      x_phase         <= x_phase_next;
      y_phase         <= y_phase_next;
      moving          <= moving_next;
      moving_axis     <= moving_axis_next;
      moving_backward <= moving_backward_next;
      steps_left      <= steps_left_next;
      wait_left       <= wait_left_next;
    end
  end

  // Result shows the state after the item
  always_comb begin
    res.x_coils   = (moving_next && moving_axis_next == AXIS_X) ? coil_of(x_phase_next) : 4'h0;
    res.y_coils   = (moving_next && moving_axis_next == AXIS_Y) ? coil_of(y_phase_next) : 4'h0;
    res.busy_res  = moving_next;
    res.move_done = done;
    res.rejected  = rej;
  end

  // A move in progress always has a wait running
  a_wait_running: assert property (@(posedge clk) disable iff (rst)
    moving |-> wait_left != '0) else $error("moving with empty wait counter");

  // Idle never leaves steps pending
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !moving |-> steps_left == '0) else $error("idle with steps pending");

  // A move only starts from an accepted command
  a_start_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(moving) |-> $past(proc && item.action == ACT_MOVE))
    else $error("move started without a command");

  // Idle result releases all coils
  a_coils_off: assert property (@(posedge clk) disable iff (rst)
    !res.busy_res |-> (res.x_coils == 4'h0 && res.y_coils == 4'h0))
    else $error("coils driven while idle");

  // Finish and reject never share a result
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !(res.move_done && res.rejected)) else $error("done and rejected together");

endmodule

// ===== hw/rtl/two_axis_stepper_sequencer_core.sv =====
// Top level: input register, sequencer core and result register.
//
//  channel  direction  tdata / data fields (low bit first)          tuser
//  s_axis   in         axis, direction, step_count[15:0], 0-pad      action
//  m_axis   out        x_coils, y_coils, busy_res, move_done,        -
//                      rejected, 0-pad
//  cfg      in         cfg_we, cfg_index (0 x period, 1 y period),   -
//                      cfg_data[7:0]
//
// One item per cycle while m_tready does not stall; a result passes through the
// input register and then the result register around the core before it can
// transfer.
// Every item yields exactly one result. rst is synchronous and clears
// both valid flags, the motion state, phases (to 3) and periods (to 15).
// A stalled m_tready holds the result and backs up into s_tready.
module two_axis_stepper_sequencer_core import tass_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // axis, direction, step_count[15:0], zero pad
  input  logic                 s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // x_coils, y_coils, busy_res, move_done, rejected, pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic    in_valid;
  item_t   in_item;
  logic    adv;
  logic    proc;
  result_t res;
  result_t out_res;

  assign adv      = !m_tvalid || m_tready;
  assign proc     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action     <= s_tuser;
      in_item.axis       <= s_tdata[0];
      in_item.direction  <= s_tdata[1];
      in_item.step_count <= s_tdata[COUNT_W+1:2];
    end
  end

  tass_core u_core (
    .clk       (clk),
    .rst       (rst),
    .proc      (proc),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res <= res;
    end
  end

  assign m_tdata = M_DATA_W'(out_res);

endmodule
